@@ sv/text_console_line_wrapper_unit_defines.svh @@
// Assertion macros for the text console line wrapper.
// Used by the top level only; expects clk and rst_n in the enclosing scope.
`ifndef TEXT_CONSOLE_LINE_WRAPPER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_LINE_WRAPPER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tcw_pkg.sv @@
// Shared types, constants and the microcode table of the line wrapper.
// No dependencies; every other source file of the block but the assertion header uses it.
`default_nettype none

package tcw_pkg;

    localparam int LINE_COUNT_DEF  = 32;
    localparam int LINE_LENGTH_DEF = 128;
    localparam int WIDTH_CAP       = 126;

    typedef logic [7:0] char_t;
    typedef logic [6:0] col_t;
    typedef logic [4:0] row_out_t;

    localparam col_t  WIDTH_MIN   = 7'd3;
    localparam col_t  WIDTH_RESET = 7'd80;
    localparam col_t  PREFIX_LEN  = 7'd2;

    localparam char_t NUL_CHAR   = 8'd0;
    localparam char_t TAB_CHAR   = 8'd9;
    localparam char_t NL_CHAR    = 8'd10;
    localparam char_t MARK_CHAR  = 8'd26;
    localparam char_t SPACE_CHAR = 8'd32;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    // Microcode addresses.
    localparam upc_t UPC_TAB_SPACE = 4'd0;
    localparam upc_t UPC_FINISH    = 4'd1;
    localparam upc_t UPC_NL_0      = 4'd2;
    localparam upc_t UPC_NL_1      = 4'd3;
    localparam upc_t UPC_TAB_WRAP  = 4'd4;
    localparam upc_t UPC_WRAP_0    = 4'd5;
    localparam upc_t UPC_WRAP_1    = 4'd6;
    localparam upc_t UPC_WRAP_2    = 4'd7;
    localparam upc_t UPC_WRAP_3    = 4'd8;
    localparam upc_t UPC_CHAR      = 4'd9;

    typedef enum logic [2:0] {
        BSEL_ZERO,
        BSEL_NL,
        BSEL_MARK,
        BSEL_SPACE,
        BSEL_CHAR
    } byte_sel_t;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_INC,
        COP_CLEAR,
        COP_PREFIX,
        COP_WIDTH
    } cur_op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_NOT_STOP,
        COND_TAB
    } cond_t;

    typedef struct packed {
        logic      emit;
        logic      last;
        byte_sel_t bsel;
        logic      col_p1;
        cur_op_t   cop;
        logic      row_inc;
        cond_t     cond;
        upc_t      target;
    } ctl_t;

    typedef struct packed {
        logic out_free;
        logic at_stop;
        logic is_tab;
    } stat_t;

    localparam ctl_t CTL_NOP = '{
        emit: 1'b0, last: 1'b0, bsel: BSEL_ZERO, col_p1: 1'b0, cop: COP_HOLD,
        row_inc: 1'b0, cond: COND_ALWAYS, target: UPC_FINISH
    };

    // Control store. A false condition falls through to the next address.
    function automatic ctl_t ucode(upc_t pc);
        ctl_t c;
        c = CTL_NOP;
        unique case (pc)
            UPC_TAB_SPACE:
            begin
                c.emit = 1'b1; c.bsel = BSEL_SPACE; c.cop = COP_INC;
                c.cond = COND_NOT_STOP; c.target = UPC_TAB_SPACE;
            end
            UPC_FINISH:
            begin
                c.emit = 1'b1; c.last = 1'b1; c.bsel = BSEL_ZERO;
            end
            UPC_NL_0:
            begin
                c.emit = 1'b1; c.bsel = BSEL_NL; c.target = UPC_NL_1;
            end
            UPC_NL_1:
            begin
                c.emit = 1'b1; c.bsel = BSEL_ZERO; c.col_p1 = 1'b1;
                c.row_inc = 1'b1; c.cop = COP_CLEAR; c.target = UPC_FINISH;
            end
            UPC_TAB_WRAP:
            begin
                c.cop = COP_WIDTH; c.target = UPC_WRAP_0;
            end
            UPC_WRAP_0:
            begin
                c.emit = 1'b1; c.bsel = BSEL_NL; c.target = UPC_WRAP_1;
            end
            UPC_WRAP_1:
            begin
                c.emit = 1'b1; c.bsel = BSEL_ZERO; c.col_p1 = 1'b1;
                c.row_inc = 1'b1; c.cop = COP_CLEAR; c.target = UPC_WRAP_2;
            end
            UPC_WRAP_2:
            begin
                c.emit = 1'b1; c.bsel = BSEL_MARK; c.target = UPC_WRAP_3;
            end
            UPC_WRAP_3:
            begin
                c.emit = 1'b1; c.bsel = BSEL_SPACE; c.col_p1 = 1'b1;
                c.cop = COP_PREFIX; c.cond = COND_TAB; c.target = UPC_FINISH;
            end
            UPC_CHAR:
            begin
                c.emit = 1'b1; c.bsel = BSEL_CHAR; c.cop = COP_INC;
                c.target = UPC_FINISH;
            end
            default:
            begin
                c = CTL_NOP;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/tcw_if.sv @@
// Channel interfaces of the line wrapper: characters in, writes out, width register.
// Depends on tcw_pkg for the payload types.
`default_nettype none

interface tcw_char_if;
    logic            valid;
    logic            ready;
    tcw_pkg::char_t  char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface tcw_write_if;
    logic              valid;
    logic              ready;
    tcw_pkg::row_out_t row;
    tcw_pkg::col_t     column;
    tcw_pkg::char_t    byte_out;
    logic              last;

    modport source (output valid, output row, output column, output byte_out, output last,
                    input ready);
    modport sink   (input valid, input row, input column, input byte_out, input last,
                    output ready);
endinterface

interface tcw_cfg_if;
    logic           valid;
    logic           ready;
    tcw_pkg::col_t  wrap_width;

    modport source (output valid, output wrap_width, input ready);
    modport sink   (input valid, input wrap_width, output ready);
endinterface

`default_nettype wire

@@ sv/tcw_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on tcw_pkg for the control word and the microcode table.
`default_nettype none

module tcw_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire tcw_pkg::upc_t  entry,
    input  wire tcw_pkg::stat_t stat,
    output tcw_pkg::ctl_t       ctl,
    output logic                fire,
    output logic                idle
);
    import tcw_pkg::*;

    logic busy_reg, busy_next;
    upc_t pc_reg, pc_next;
    logic cond_true;

    assign ctl  = ucode(pc_reg);
    assign fire = busy_reg && (!ctl.emit || stat.out_free);
    assign idle = !busy_reg;

    always_comb
    begin
        unique case (ctl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NOT_STOP: cond_true = !stat.at_stop;
            COND_TAB:      cond_true = stat.is_tab;
            default:       cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            pc_next   = entry;
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            pc_next = cond_true ? ctl.target : pc_reg + 1'b1;
            if (ctl.last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= UPC_FINISH;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/tcw_dpath.sv @@
// Datapath: cursor, current row, held character, entry decode and the write register.
// Depends on tcw_pkg and on tcw_write_if.
`default_nettype none

module tcw_dpath #(
    parameter int LINE_COUNT = tcw_pkg::LINE_COUNT_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire tcw_pkg::char_t char_in,
    input  wire tcw_pkg::col_t  width,
    input  wire tcw_pkg::ctl_t  ctl,
    input  wire logic           fire,
    output tcw_pkg::upc_t       entry,
    output tcw_pkg::stat_t      stat,
    tcw_write_if.source         writes
);
    import tcw_pkg::*;

    localparam int ROW_W = (LINE_COUNT > 2) ? $clog2(LINE_COUNT) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(LINE_COUNT - 1);

    char_t            char_reg;
    col_t             cursor_reg, cursor_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             wr_valid_reg, wr_valid_next;
    row_out_t         wr_row_reg;
    col_t             wr_col_reg;
    char_t            wr_byte_reg;
    logic             wr_last_reg;

    logic             load;
    char_t            byte_sel;
    logic [5:0]       stop_quad;
    logic [7:0]       tab_stop;

    // Next tab stop is the following multiple of four above the cursor.
    assign stop_quad = {1'b0, cursor_reg[6:2]} + 6'd1;
    assign tab_stop  = {stop_quad, 2'b00};

    always_comb
    begin
        priority if (char_in == TAB_CHAR)
        begin
            entry = (tab_stop >= {1'b0, width}) ? UPC_TAB_WRAP : UPC_TAB_SPACE;
        end
        else if (char_in == NL_CHAR)
        begin
            entry = UPC_NL_0;
        end
        else if (char_in == NUL_CHAR)
        begin
            entry = UPC_FINISH;
        end
        else if (cursor_reg >= width)
        begin
            entry = UPC_WRAP_0;
        end
        else
        begin
            entry = UPC_CHAR;
        end
    end

    assign stat.out_free = !wr_valid_reg || writes.ready;
    assign stat.at_stop  = (cursor_reg[1:0] == 2'b11);
    assign stat.is_tab   = (char_reg == TAB_CHAR);

    assign load = fire && ctl.emit;

    always_comb
    begin
        unique case (ctl.bsel)
            BSEL_ZERO:  byte_sel = NUL_CHAR;
            BSEL_NL:    byte_sel = NL_CHAR;
            BSEL_MARK:  byte_sel = MARK_CHAR;
            BSEL_SPACE: byte_sel = SPACE_CHAR;
            BSEL_CHAR:  byte_sel = char_reg;
            default:    byte_sel = NUL_CHAR;
        endcase
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        row_next    = row_reg;
        if (fire)
        begin
            unique case (ctl.cop)
                COP_HOLD:   cursor_next = cursor_reg;
                COP_INC:    cursor_next = cursor_reg + 1'b1;
                COP_CLEAR:  cursor_next = '0;
                COP_PREFIX: cursor_next = PREFIX_LEN;
                COP_WIDTH:  cursor_next = width;
                default:    cursor_next = cursor_reg;
            endcase
            if (ctl.row_inc)
            begin
                row_next = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_valid_next = wr_valid_reg;
        if (load)
        begin
            wr_valid_next = 1'b1;
        end
        else if (writes.ready)
        begin
            wr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            row_reg      <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg   <= cursor_next;
            row_reg      <= row_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_in;
        end
        if (load)
        begin
            wr_row_reg  <= row_out_t'(row_reg);
            wr_col_reg  <= ctl.col_p1 ? cursor_reg + 1'b1 : cursor_reg;
            wr_byte_reg <= byte_sel;
            wr_last_reg <= ctl.last;
        end
    end

    assign writes.valid    = wr_valid_reg;
    assign writes.row      = wr_row_reg;
    assign writes.column   = wr_col_reg;
    assign writes.byte_out = wr_byte_reg;
    assign writes.last     = wr_last_reg;

endmodule

`default_nettype wire

@@ sv/text_console_line_wrapper_unit.sv @@
// Top level of the text console line wrapper: width register, sequencer and datapath.
// Depends on tcw_pkg, the tcw interfaces, tcw_seq, tcw_dpath and the assertion header.
//
//  channel  modport  payload                          request moved
//  chars    sink     char_in[7:0]                     one text byte
//  writes   source   row[4:0] column[6:0] byte_out[7:0] last   one byte write into the ring
//  cfg      sink     wrap_width[6:0]                  new wrap column
//
// A character is taken when the sequencer is idle, then the microcode runs one step per
// cycle, each step making at most one write; a step that writes stalls while the write
// register holds a write that the writes channel has not taken. A tab that wraps spends
// one extra step loading the cursor. The single write register lets a step load its write
// in the same cycle as the waiting write is taken.
// Reset clears cursor, row and control and sets the wrap column to 80; cfg is always ready.
`default_nettype none
`include "text_console_line_wrapper_unit_defines.svh"

module text_console_line_wrapper_unit #(
    parameter int LINE_COUNT  = tcw_pkg::LINE_COUNT_DEF,
    parameter int LINE_LENGTH = tcw_pkg::LINE_LENGTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tcw_char_if.sink     chars,
    tcw_write_if.source  writes,
    tcw_cfg_if.sink      cfg
);
    import tcw_pkg::*;

    localparam col_t WIDTH_MAX =
        7'(((LINE_LENGTH - 2) < WIDTH_CAP) ? (LINE_LENGTH - 2) : WIDTH_CAP);

    col_t  width_reg, width_next;
    col_t  width_eff;
    logic  accept;
    logic  idle;
    logic  fire;
    upc_t  entry;
    ctl_t  ctl;
    stat_t stat;
    logic  last_pending;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_next = width_reg;
        if (cfg.valid)
        begin
            width_next = cfg.wrap_width;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else
        begin
            width_reg <= width_next;
        end
    end

    always_comb
    begin
        priority if (width_reg < WIDTH_MIN)
        begin
            width_eff = WIDTH_MIN;
        end
        else if (width_reg > WIDTH_MAX)
        begin
            width_eff = WIDTH_MAX;
        end
        else
        begin
            width_eff = width_reg;
        end
    end

    assign chars.ready = idle;
    assign accept      = chars.valid && idle;

    tcw_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .entry  (entry),
        .stat   (stat),
        .ctl    (ctl),
        .fire   (fire),
        .idle   (idle)
    );

    tcw_dpath #(
        .LINE_COUNT (LINE_COUNT)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (chars.char_in),
        .width   (width_eff),
        .ctl     (ctl),
        .fire    (fire),
        .entry   (entry),
        .stat    (stat),
        .writes  (writes)
    );

    assign last_pending = writes.valid && writes.last;

    // Taking a character must start the program, so the input closes once the sequencer is busy.
    `TCW_ASSERT_NEXT(a_busy_after_accept, accept, !chars.ready, "input still open after accept")
    // A pending write that is not the final one means the program has not finished.
    `TCW_ASSERT_SAME(a_mid_item_busy, writes.valid && !writes.last, !idle, "idle before last write")
    // Every request closes with the terminator at the cursor.
    `TCW_ASSERT_SAME(a_last_nul, last_pending, writes.byte_out == NUL_CHAR, "last byte not 0")

endmodule

`default_nettype wire

@@ tb/line_write_checker.sv @@
`timescale 1ns / 100ps
// Checker for the line wrapper: predicts the ring writes of each accepted character request
// and compares them in order with the writes leaving the block. Depends on tcw_pkg and tcw_if.
module line_write_checker (
    input  logic clk,
    input  logic rst_n,
    tcw_char_if  chars,
    tcw_write_if writes,
    tcw_cfg_if   cfg,
    output int   mismatch_count,
    output int   writes_outstanding
);
    import tcw_pkg::*;

    localparam int TAB_SPAN = 4;

    typedef struct packed {
        row_out_t row;
        col_t     column;
        char_t    byte_out;
        logic     last;
    } ring_write_t;

    ring_write_t expected_writes[$];
    col_t        wrap_col;
    int          cursor_col;
    row_out_t    line_row;

    task automatic log_write(input int col, input char_t b, input logic fin);
        ring_write_t w;
        w.row      = line_row;
        w.column   = col_t'(col);
        w.byte_out = b;
        w.last     = fin;
        expected_writes.push_back(w);
    endtask

    task automatic advance_row();
        line_row   = row_out_t'((int'(line_row) + 1) % LINE_COUNT_DEF);
        cursor_col = 0;
    endtask

    // Close the current line at the cursor and open the next one with the wrap marker.
    task automatic break_line();
        log_write(cursor_col, NL_CHAR, 1'b0);
        log_write(cursor_col + 1, NUL_CHAR, 1'b0);
        advance_row();
        log_write(0, MARK_CHAR, 1'b0);
        log_write(1, SPACE_CHAR, 1'b0);
        cursor_col = int'(PREFIX_LEN);
    endtask

    task automatic predict_char_writes(input char_t c);
        int lim;
        int tab_stop;
        lim = int'(wrap_col);
        if (lim > LINE_LENGTH_DEF - 2)
            lim = LINE_LENGTH_DEF - 2;
        if (lim > WIDTH_CAP)
            lim = WIDTH_CAP;
        if (lim < int'(WIDTH_MIN))
            lim = int'(WIDTH_MIN);

        if (c == TAB_CHAR)
        begin
            tab_stop = TAB_SPAN * ((cursor_col + TAB_SPAN) / TAB_SPAN);
            // A stop at or beyond the width wraps from the width, even when the
            // cursor already sits past it after the width was lowered.
            if (tab_stop >= lim)
            begin
                cursor_col = lim;
                break_line();
            end
            else
            begin
                while (cursor_col < tab_stop)
                begin
                    log_write(cursor_col, SPACE_CHAR, 1'b0);
                    cursor_col++;
                end
            end
        end
        else if (c == NL_CHAR)
        begin
            log_write(cursor_col, NL_CHAR, 1'b0);
            log_write(cursor_col + 1, NUL_CHAR, 1'b0);
            advance_row();
        end
        else if (c != NUL_CHAR)
        begin
            if (cursor_col >= lim)
                break_line();
            log_write(cursor_col, c, 1'b0);
            cursor_col++;
        end

        log_write(cursor_col, NUL_CHAR, 1'b1);
        cursor_col = cursor_col & 127;
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ring_write_t want;
        if (!rst_n)
        begin
            expected_writes.delete();
            wrap_col           = WIDTH_RESET;
            cursor_col         = 0;
            line_row           = '0;
            writes_outstanding = 0;
        end
        else
        begin
            if (writes.valid && writes.ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected write: row %0d, column %0d, byte %0d, last %0d",
                           writes.row, writes.column, writes.byte_out, writes.last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    check_field("row", 8'(want.row), 8'(writes.row));
                    check_field("column", 8'(want.column), 8'(writes.column));
                    check_field("byte_out", want.byte_out, writes.byte_out);
                    check_field("last", 8'(want.last), 8'(writes.last));
                end
            end
            if (cfg.valid && cfg.ready)
                wrap_col = cfg.wrap_width;
            if (chars.valid && chars.ready)
                predict_char_writes(chars.char_in);
            writes_outstanding = expected_writes.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the line wrapper testbench: clock, reset, character and width requests, verdict.
// Depends on tcw_pkg, tcw_if, text_console_line_wrapper_unit and line_write_checker.
module tb_top;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic clk;
    logic rst_n;
    int   send_idle_pct  = 28;
    int   recv_stall_pct = 64;
    int   mismatch_count;
    int   writes_outstanding;
    int   cycle_count;

    tcw_char_if  chars_ch ();
    tcw_write_if writes_ch ();
    tcw_cfg_if   cfg_ch ();

    text_console_line_wrapper_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_ch),
        .writes (writes_ch),
        .cfg    (cfg_ch)
    );

    line_write_checker line_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .chars              (chars_ch),
        .writes             (writes_ch),
        .cfg                (cfg_ch),
        .mismatch_count     (mismatch_count),
        .writes_outstanding (writes_outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
        writes_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_char(input char_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_ch.valid <= 1'b0;
            @(negedge clk);
        end
        chars_ch.valid   <= 1'b1;
        chars_ch.char_in <= c;
        @(posedge clk);
        while (!chars_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        chars_ch.valid <= 1'b0;
        @(negedge clk);
        while (writes_outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_width(input col_t w);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.wrap_width <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_text(input int count, input int nl_pct, input int tab_pct);
        int    hold_at;
        int    pick;
        char_t c;
        hold_at = $urandom_range(count - 1);
        for (int i = 0; i < count; i++)
        begin
            // Once per stream the sender holds back until every write is in.
            if (i == hold_at)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < nl_pct)
                c = NL_CHAR;
            else if (pick < nl_pct + tab_pct)
                c = TAB_CHAR;
            else if (pick < nl_pct + tab_pct + 2)
                c = NUL_CHAR;
            else
                c = char_t'($urandom_range(255, 1));
            send_char(c);
        end
    endtask

    initial
    begin
        chars_ch.valid    = 1'b0;
        chars_ch.char_in  = NUL_CHAR;
        writes_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.wrap_width = '0;
        rst_n             = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default width: extreme bytes, two tabs, a newline and a zero byte.
        send_char(8'h41);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(8'h80);
        send_char(8'h7F);
        send_char(TAB_CHAR);
        send_char(NL_CHAR);
        send_char(NUL_CHAR);
        send_char(TAB_CHAR);
        send_char(8'hAA);
        send_char(8'h55);

        // The cursor is now past a width of four, so the first character wraps
        // at the cursor; a later one wraps at the width, and so does the tab.
        set_width(7'd4);
        send_char(8'h71);
        send_char(8'h72);
        send_char(8'h73);
        send_char(TAB_CHAR);
        send_char(8'h61);
        send_char(8'h62);

        // A width below the minimum acts as the minimum; the tab starts past it.
        set_width(7'd1);
        send_char(TAB_CHAR);
        send_char(NL_CHAR);
        send_char(8'h5A);

        set_width(7'd127);
        send_random_text(110, 1, 40);

        send_idle_pct  = 64;
        recv_stall_pct = 28;
        set_width(7'd3);
        send_random_text(60, 10, 15);
        set_width(7'd0);
        send_random_text(50, 10, 15);
        set_width(col_t'($urandom_range(126, 3)));
        send_random_text(70, 5, 10);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_width(7'd20);
        send_random_text(60, 5, 15);
        set_width(7'd126);
        send_random_text(80, 1, 40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/tcw_seq.sv
sv/tcw_dpath.sv
sv/text_console_line_wrapper_unit.sv
tb/line_write_checker.sv
tb/tb_top.sv
